FILE: rtl/sed_pkg.sv
`timescale 1ns / 1ps

package sed_pkg;

  localparam int CHAR_W  = 16;
  localparam int OFF_W   = 12;
  localparam int EVAL_W  = 9;
  localparam int RES_MAX = 5;
  localparam int CNT_W   = $clog2(RES_MAX + 1);

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int MAX_LITERAL_LEN = 4096;
  localparam int POS_CAP_I = (MAX_LITERAL_LEN - 1 > 4095) ? 4095 : MAX_LITERAL_LEN - 1;
  localparam logic [OFF_W-1:0] POS_CAP = OFF_W'(POS_CAP_I);

  localparam logic [CHAR_W-1:0] BSL_CH = 16'h005C;
  localparam logic [CHAR_W-1:0] X_CH   = 16'h0078;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_BSL     = 3'd1,
    M_OCT     = 3'd2,
    M_HEX     = 3'd3,
    M_OCTLONG = 3'd4,
    M_HEXLONG = 3'd5
  } mode_t;

  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE   = 2'd0;
  localparam err_t ERR_LETTER = 2'd1;
  localparam err_t ERR_HEX    = 2'd2;
  localparam err_t ERR_OCT    = 2'd3;

  // all results caused by one input beat
  typedef struct packed {
    logic [CNT_W-1:0]              cnt;
    logic [RES_MAX-1:0][CHAR_W-1:0] chars;
    err_t                          err;
    logic [OFF_W-1:0]              off;
    logic                          last;
  } bundle_t;

endpackage

FILE: rtl/sed_front.sv
`timescale 1ns / 1ps

module sed_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              in_char,
  input  logic                     in_last,
  input  logic                     q_full,
  output logic                     q_push,
  output sed_pkg::bundle_t         q_wdata
);

  sed_pkg::mode_t                  mode_r, mode_nxt;
  logic [1:0]                      dcnt_r, dcnt_nxt;
  logic [sed_pkg::EVAL_W-1:0]      eval_r, eval_nxt;
  logic [sed_pkg::OFF_W-1:0]       pos_r, pos_nxt;
  logic [sed_pkg::OFF_W-1:0]       estart_r, estart_nxt;
  logic [sed_pkg::CHAR_W-1:0]      raw_r [3];

  logic                            acc;
  logic                            raw_we;
  logic [1:0]                      raw_idx;
  logic                            is_oct, hex_ok, do_fresh;
  logic [3:0]                      hex_v;
  logic [8:0]                      let_v;
  logic [sed_pkg::CHAR_W-1:0]      raw0_post;
  sed_pkg::bundle_t                b;

  function automatic sed_pkg::bundle_t put(sed_pkg::bundle_t bi,
                                           logic [sed_pkg::CHAR_W-1:0] x);
    sed_pkg::bundle_t r;
    r = bi;
    if (bi.cnt < sed_pkg::CNT_W'(sed_pkg::RES_MAX)) begin
      r.chars[bi.cnt] = x;
      r.cnt = bi.cnt + sed_pkg::CNT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [8:0] letter_code(logic [sed_pkg::CHAR_W-1:0] ch);
    logic [8:0] r;
    case (ch)
      16'h0061: r = {1'b1, 8'd7};
      16'h0062: r = {1'b1, 8'd8};
      16'h0066: r = {1'b1, 8'd12};
      16'h006E: r = {1'b1, 8'd10};
      16'h0072: r = {1'b1, 8'd13};
      16'h0074: r = {1'b1, 8'd9};
      16'h0076: r = {1'b1, 8'd11};
      16'h0027: r = {1'b1, 8'd39};
      16'h0022: r = {1'b1, 8'd34};
      16'h005C: r = {1'b1, 8'd92};
      16'h003F: r = {1'b1, 8'd63};
      default:  r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [sed_pkg::CHAR_W-1:0] ext(logic [sed_pkg::EVAL_W-1:0] v);
    return {{(sed_pkg::CHAR_W - sed_pkg::EVAL_W){1'b0}}, v};
  endfunction

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc && (b.cnt != '0);
  assign q_wdata  = b;

  always_comb begin
    is_oct = in_char inside {[16'h0030:16'h0037]};
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (in_char inside {[16'h0030:16'h0039]}) begin
      hex_v = in_char[3:0];
    end else if (in_char inside {[16'h0061:16'h0066], [16'h0041:16'h0046]}) begin
      hex_v = in_char[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
    let_v = letter_code(in_char);
  end

  always_comb begin
    mode_nxt   = mode_r;
    dcnt_nxt   = dcnt_r;
    eval_nxt   = eval_r;
    pos_nxt    = pos_r;
    estart_nxt = estart_r;
    raw_we     = 1'b0;
    raw_idx    = 2'd0;
    do_fresh   = 1'b0;
    b          = '0;
    b.err      = sed_pkg::ERR_NONE;
    b.last     = in_last;

    case (mode_r)
      sed_pkg::M_BSL: begin
        mode_nxt = sed_pkg::M_IDLE;
        if (let_v[8]) begin
          b = put(b, {8'd0, let_v[7:0]});
        end else if (is_oct) begin
          raw_we   = 1'b1;
          raw_idx  = 2'd0;
          eval_nxt = {6'd0, in_char[2:0]};
          dcnt_nxt = 2'd1;
          mode_nxt = sed_pkg::M_OCT;
        end else if (in_char == sed_pkg::X_CH) begin
          raw_we   = 1'b1;
          raw_idx  = 2'd0;
          eval_nxt = '0;
          dcnt_nxt = 2'd0;
          mode_nxt = sed_pkg::M_HEX;
        end else begin
          b = put(b, sed_pkg::BSL_CH);
          b = put(b, in_char);
          b.err = sed_pkg::ERR_LETTER;
        end
      end
      sed_pkg::M_OCT: begin
        if (is_oct) begin
          if (dcnt_r < 2'd3) begin
            raw_we   = 1'b1;
            raw_idx  = dcnt_r;
            eval_nxt = {eval_r[5:0], in_char[2:0]};
            dcnt_nxt = dcnt_r + 2'd1;
          end else begin
            b = put(b, sed_pkg::BSL_CH);
            b = put(b, raw_r[0]);
            b = put(b, raw_r[1]);
            b = put(b, raw_r[2]);
            b = put(b, in_char);
            b.err = sed_pkg::ERR_OCT;
            mode_nxt = sed_pkg::M_OCTLONG;
          end
        end else begin
          b = put(b, ext(eval_r));
          do_fresh = 1'b1;
        end
      end
      sed_pkg::M_HEX: begin
        if (hex_ok) begin
          if (dcnt_r < 2'd2) begin
            raw_we   = 1'b1;
            raw_idx  = dcnt_r + 2'd1;
            eval_nxt = {eval_r[4:0], hex_v};
            dcnt_nxt = dcnt_r + 2'd1;
          end else begin
            b = put(b, sed_pkg::BSL_CH);
            b = put(b, raw_r[0]);
            b = put(b, raw_r[1]);
            b = put(b, raw_r[2]);
            b = put(b, in_char);
            b.err = sed_pkg::ERR_HEX;
            mode_nxt = sed_pkg::M_HEXLONG;
          end
        end else begin
          if (dcnt_r == 2'd0) begin
            b = put(b, sed_pkg::BSL_CH);
            b = put(b, raw_r[0]);
          end else begin
            b = put(b, ext(eval_r));
          end
          do_fresh = 1'b1;
        end
      end
      sed_pkg::M_OCTLONG: begin
        if (is_oct) begin
          b = put(b, in_char);
          b.err = sed_pkg::ERR_OCT;
        end else begin
          do_fresh = 1'b1;
        end
      end
      sed_pkg::M_HEXLONG: begin
        if (hex_ok) begin
          b = put(b, in_char);
          b.err = sed_pkg::ERR_HEX;
        end else begin
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    if (do_fresh) begin
      mode_nxt = sed_pkg::M_IDLE;
      if (in_char == sed_pkg::BSL_CH) begin
        mode_nxt   = sed_pkg::M_BSL;
        estart_nxt = pos_r;
      end else begin
        b = put(b, in_char);
      end
    end

    b.off = (b.err != sed_pkg::ERR_NONE) ? estart_r : '0;

    raw0_post = (raw_we && raw_idx == 2'd0) ? in_char : raw_r[0];

    if (in_last) begin
      case (mode_nxt)
        sed_pkg::M_BSL: b = put(b, sed_pkg::BSL_CH);
        sed_pkg::M_OCT: b = put(b, ext(eval_nxt));
        sed_pkg::M_HEX: begin
          if (dcnt_nxt == 2'd0) begin
            b = put(b, sed_pkg::BSL_CH);
            b = put(b, raw0_post);
          end else begin
            b = put(b, ext(eval_nxt));
          end
        end
        default: ;
      endcase
      mode_nxt   = sed_pkg::M_IDLE;
      dcnt_nxt   = 2'd0;
      eval_nxt   = '0;
      pos_nxt    = '0;
      estart_nxt = '0;
    end else if (pos_r < sed_pkg::POS_CAP) begin
      pos_nxt = pos_r + sed_pkg::OFF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sed_pkg::M_IDLE;
      dcnt_r   <= 2'd0;
      eval_r   <= '0;
      pos_r    <= '0;
      estart_r <= '0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      dcnt_r   <= dcnt_nxt;
      eval_r   <= eval_nxt;
      pos_r    <= pos_nxt;
      estart_r <= estart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && raw_we) begin
      raw_r[raw_idx] <= in_char;
    end
  end

  // a final character always yields at least one result
  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last) |-> (b.cnt != '0))
    else $error("last beat produced no result");

endmodule

FILE: rtl/sed_queue.sv
`timescale 1ns / 1ps

module sed_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sed_pkg::bundle_t wdata,
  output logic             full,
  output logic             valid,
  output sed_pkg::bundle_t rdata,
  input  logic             pop
);

  sed_pkg::bundle_t               mem_r [sed_pkg::QDEPTH];
  logic [sed_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [sed_pkg::QCNT_W-1:0]     count_r;
  logic                           do_push, do_pop;

  assign full    = (count_r == sed_pkg::QCNT_W'(sed_pkg::QDEPTH));
  assign valid   = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + sed_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + sed_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + sed_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - sed_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("pop from empty queue");

endmodule

FILE: rtl/sed_back.sv
`timescale 1ns / 1ps

module sed_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  sed_pkg::bundle_t            q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_char,
  output logic [1:0]                  out_err_code,
  output logic [11:0]                 out_err_offset,
  output logic                        out_run_end,
  output logic                        out_string_end
);

  logic [sed_pkg::CNT_W-1:0]   idx_r;
  logic                        out_valid_r;
  logic [15:0]                 char_r;
  logic [1:0]                  err_r;
  logic [11:0]                 off_r;
  logic                        run_end_r, string_end_r;
  logic                        load, is_end;

  assign load   = q_valid && (!out_valid_r || out_ready);
  assign is_end = (idx_r == q_data.cnt - sed_pkg::CNT_W'(1));
  assign q_pop  = load && is_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_end ? '0 : idx_r + sed_pkg::CNT_W'(1);
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r       <= q_data.chars[idx_r];
      err_r        <= q_data.err;
      off_r        <= q_data.off;
      run_end_r    <= is_end;
      string_end_r <= is_end && q_data.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = char_r;
  assign out_err_code   = err_r;
  assign out_err_offset = off_r;
  assign out_run_end    = run_end_r;
  assign out_string_end = string_end_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (q_data.cnt != '0) && (idx_r < q_data.cnt))
    else $error("result index outside bundle");

endmodule

FILE: rtl/string_escape_decoder.sv
`timescale 1ns / 1ps
// String escape decoder.
// Input channel (in_valid/in_ready): one character of a quoted literal per
// beat, quotes removed; in_last marks the final character and flushes any
// pending escape. Output channel (out_valid/out_ready): one decoded character
// per beat with error code, backslash offset of a flagged escape, run_end on
// the last result of an input beat and string_end on the last of the literal.
// A beat that only extends a pending escape yields no result; one beat yields
// at most five.
// A result of an accepted beat is written into the queue, then loaded into the
// output register once that register is free. Throughput: one input beat per
// cycle while the queue is not full; the back end emits one result per cycle
// while out_ready is high, so beats with several results can fill the queue. A
// four-entry queue of result groups sits between the decoder and the output
// register. Reset clears the escape state, the character position, the queue
// and the output valid flag. When the receiver stalls the output holds, the
// queue fills and in_ready drops once it is full.
module string_escape_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_char,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_char,
  output logic [1:0]  out_err_code,
  output logic [11:0] out_err_offset,
  output logic        out_run_end,
  output logic        out_string_end
);

  logic             q_push, q_full, q_valid, q_pop;
  sed_pkg::bundle_t q_wdata, q_rdata;

  sed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_char  (in_char),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  sed_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .valid (q_valid),
    .rdata (q_rdata),
    .pop   (q_pop)
  );

  sed_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_err_code   (out_err_code),
    .out_err_offset (out_err_offset),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end)
  );

endmodule
